// ===== rtl/core/pmu_pkg.sv =====
`default_nettype none

package pmu_pkg;

  // Fade table index width and size
  localparam int FADE_TABLE_BITS = 8;
  localparam int FADE_SIZE       = 1 << FADE_TABLE_BITS;

  // Quotient width shared by the alpha and green dividers
  localparam int QW       = (FADE_TABLE_BITS > 8) ? FADE_TABLE_BITS : 8;
  localparam int DIV_STG  = 4;                              // divider stages
  localparam int DIV_STEP = (QW + DIV_STG - 1) / DIV_STG;   // quotient bits per stage
  localparam int QT       = DIV_STG * DIV_STEP;             // quotient bits produced
  localparam int RW       = 16 + QT;                        // remainder width

  // Pipeline stages inside the datapath modules (output register comes after)
  localparam int NSTG = DIV_STG + 1;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;

  localparam logic [CFG_IW-1:0] REG_GRAVITY  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DRAG     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_GROUND   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_WIDTH    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_LIFETIME = 3'd4;

  localparam logic [23:0] GRAVITY_RST  = 24'd8389;
  localparam logic [15:0] DRAG_RST     = 16'd1311;
  localparam logic [11:0] GROUND_RST   = 12'd720;
  localparam logic [11:0] WIDTH_RST    = 12'd1280;
  localparam logic [15:0] LIFETIME_RST = 16'd500;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic        [7:0]  step_ms;
    logic        [15:0] set_age_ms;
  } pmu_in_t;

  typedef struct packed {
    logic signed [23:0] new_pos_x;
    logic signed [23:0] new_pos_y;
    logic signed [23:0] new_vel_x;
    logic signed [23:0] new_vel_y;
    logic        [7:0]  alpha;
    logic        [7:0]  green;
    logic               expired;
  } pmu_out_t;

  typedef struct packed {
    logic [23:0] gravity_q24;
    logic [15:0] drag_q16;
    logic [11:0] ground_level;
    logic [11:0] screen_width;
    logic [15:0] lifetime_ms;
  } pmu_cfg_t;

  typedef logic [7:0] fade_tab_t [FADE_SIZE];

  // Clamp to the signed 24-bit range
  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Integer square root, two bits per pass (elaboration only)
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Green level vs. age ratio: 255 * (1 - ratio^1.75)
  function automatic fade_tab_t build_fade();
    fade_tab_t   tab;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] p;
    for (int i = 0; i < FADE_SIZE; i++) begin
      r = 64'(i) << (30 - FADE_TABLE_BITS);
      s = isqrt64(r << 30);
      t = isqrt64(s << 30);
      p = (((r * s) >> 30) * t) >> 30;
      tab[i] = 8'((64'd255 * ((64'd1 << 30) - p)) >> 30);
    end
    return tab;
  endfunction

  localparam fade_tab_t FADE_TAB = build_fade();

endpackage

`default_nettype wire

// ===== rtl/core/pmu_motion.sv =====
`default_nettype none

module pmu_motion import pmu_pkg::*; (
  input  wire logic               clk,
  input  wire logic [NSTG:1]      stg_en,
  input  wire pmu_cfg_t           cfg,
  input  wire pmu_in_t            in_data,
  output logic signed [23:0]      new_pos_x,
  output logic signed [23:0]      new_pos_y,
  output logic signed [23:0]      new_vel_x,
  output logic signed [23:0]      new_vel_y
);

  // Config-derived constants
  logic        [16:0] drag_f;
  logic signed [17:0] drag_s;
  logic signed [24:0] glim_s;
  logic signed [25:0] wlim_s;

  assign drag_f = 17'h10000 - {1'b0, cfg.drag_q16};
  assign drag_s = $signed({1'b0, drag_f});
  assign glim_s = $signed({5'b0, cfg.ground_level, 8'b0});
  assign wlim_s = $signed({6'b0, cfg.screen_width, 8'b0});

  // Stage 1: x drag product, ground clamp and bounce
  logic signed [41:0] pdx1_nxt, pdx1_r;
  logic signed [23:0] x1_r;
  logic        [7:0]  dt1_r;
  logic signed [23:0] y1_nxt, y1_r;
  logic signed [23:0] vyb1_nxt, vyb1_r;
  logic               over;
  logic signed [24:0] neg_vy;
  logic signed [24:0] half_vy;

  always_comb begin
    pdx1_nxt = in_data.vel_x * drag_s;
    over     = $signed({in_data.pos_y[23], in_data.pos_y}) > glim_s;
    y1_nxt   = over ? glim_s[23:0] : in_data.pos_y;
    neg_vy   = 25'sd1 - $signed({in_data.vel_y[23], in_data.vel_y});
    half_vy  = neg_vy >>> 1;
    vyb1_nxt = (over && (in_data.vel_y > 24'sd0)) ? half_vy[23:0] : in_data.vel_y;
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      pdx1_r <= pdx1_nxt;
      x1_r   <= in_data.pos_x;
      dt1_r  <= in_data.step_ms;
      y1_r   <= y1_nxt;
      vyb1_r <= vyb1_nxt;
    end
  end

  // Stage 2: round and clamp x speed, y drag product
  logic signed [41:0] r16x;
  logic signed [23:0] vx2_nxt, vx2_r;
  logic signed [41:0] pdy2_nxt, pdy2_r;
  logic signed [23:0] x2_r, y2_r;
  logic        [7:0]  dt2_r;

  always_comb begin
    r16x     = (pdx1_r + 42'sd32768) >>> 16;
    vx2_nxt  = sat24(r16x[31:0]);
    pdy2_nxt = vyb1_r * drag_s;
  end

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      vx2_r  <= vx2_nxt;
      pdy2_r <= pdy2_nxt;
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      dt2_r  <= dt1_r;
    end
  end

  // Stage 3: x step product, round y speed, gravity times step
  logic signed [32:0] pxd3_nxt, pxd3_r;
  logic signed [41:0] r16y;
  logic signed [23:0] vy3_nxt, vy3_r;
  logic        [31:0] gdt3_nxt, gdt3_r;
  logic signed [23:0] x3_r, vx3_r, y3_r;
  logic        [7:0]  dt3_r;

  always_comb begin
    pxd3_nxt = vx2_r * $signed({1'b0, dt2_r});
    r16y     = (pdy2_r + 42'sd32768) >>> 16;
    vy3_nxt  = r16y[23:0];
    gdt3_nxt = cfg.gravity_q24 * dt2_r;
  end

  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      pxd3_r <= pxd3_nxt;
      vy3_r  <= vy3_nxt;
      gdt3_r <= gdt3_nxt;
      x3_r   <= x2_r;
      vx3_r  <= vx2_r;
      y3_r   <= y2_r;
      dt3_r  <= dt2_r;
    end
  end

  // Stage 4: move x, y speed and gravity products, new y speed
  logic signed [33:0] r8x;
  logic signed [25:0] x4_nxt, x4_r;
  logic signed [32:0] pvd4_nxt, pvd4_r;
  logic        [39:0] gdd4_nxt, gdd4_r;
  logic        [32:0] gr8;
  logic signed [26:0] vysum;
  logic signed [23:0] vyn4_nxt, vyn4_r;
  logic signed [23:0] vx4_r, y4_r;

  always_comb begin
    r8x      = $signed({pxd3_r[32], pxd3_r} + 34'sd128) >>> 8;
    x4_nxt   = $signed({{2{x3_r[23]}}, x3_r}) + $signed(r8x[25:0]);
    pvd4_nxt = vy3_r * $signed({1'b0, dt3_r});
    gdd4_nxt = gdt3_r * dt3_r;
    gr8      = ({1'b0, gdt3_r} + 33'd128) >> 8;
    vysum    = $signed({{3{vy3_r[23]}}, vy3_r}) + $signed({2'b0, gr8[24:0]});
    vyn4_nxt = sat24({{5{vysum[26]}}, vysum});
  end

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      x4_r   <= x4_nxt;
      pvd4_r <= pvd4_nxt;
      gdd4_r <= gdd4_nxt;
      vyn4_r <= vyn4_nxt;
      vx4_r  <= vx3_r;
      y4_r   <= y3_r;
    end
  end

  // Stage 5: wrap x, move y with gravity term
  logic signed [42:0] ysum;
  logic signed [42:0] yr17;
  logic signed [26:0] yt;
  logic signed [23:0] x5_nxt, x5_r;
  logic signed [23:0] y5_nxt, y5_r;
  logic signed [23:0] vx5_r, vyn5_r;

  always_comb begin
    if (x4_r < 26'sd0) begin
      x5_nxt = wlim_s[23:0];
    end else if (x4_r > wlim_s) begin
      x5_nxt = '0;
    end else begin
      x5_nxt = x4_r[23:0];
    end
    ysum   = ($signed({{10{pvd4_r[32]}}, pvd4_r}) <<< 9) + $signed({3'b0, gdd4_r})
             + 43'sd65536;
    yr17   = ysum >>> 17;
    yt     = $signed({{3{y4_r[23]}}, y4_r}) + $signed(yr17[26:0]);
    y5_nxt = sat24({{5{yt[26]}}, yt});
  end

  always_ff @(posedge clk) begin
    if (stg_en[5]) begin
      x5_r   <= x5_nxt;
      y5_r   <= y5_nxt;
      vx5_r  <= vx4_r;
      vyn5_r <= vyn4_r;
    end
  end

  assign new_pos_x = x5_r;
  assign new_pos_y = y5_r;
  assign new_vel_x = vx5_r;
  assign new_vel_y = vyn5_r;

endmodule

`default_nettype wire

// ===== rtl/core/pmu_fade.sv =====
`default_nettype none

module pmu_fade import pmu_pkg::*; (
  input  wire logic          clk,
  input  wire logic [NSTG:1] stg_en,
  input  wire pmu_cfg_t      cfg,
  input  wire pmu_in_t       in_data,
  output logic        [7:0]  alpha,
  output logic        [7:0]  green,
  output logic               expired
);

  logic [RW-1:0] rem_a_r [1:NSTG-1];
  logic [RW-1:0] rem_g_r [1:NSTG-1];
  logic [RW-1:0] rem_a_nxt [2:NSTG];
  logic [RW-1:0] rem_g_nxt [2:NSTG];
  logic [QT-1:0] q_a_r   [1:NSTG];
  logic [QT-1:0] q_g_r   [1:NSTG];
  logic [QT-1:0] q_a_nxt [2:NSTG];
  logic [QT-1:0] q_g_nxt [2:NSTG];
  logic [NSTG:1] lt_r;
  logic [NSTG:1] exp_r;

  // Stage 1: dividends 255*(L-age) and age<<B, live and expired flags
  logic        lt1_nxt;
  logic        exp1_nxt;
  logic [15:0] diff;
  logic [23:0] na;

  always_comb begin
    lt1_nxt  = in_data.set_age_ms < cfg.lifetime_ms;
    exp1_nxt = ({1'b0, in_data.set_age_ms} + {9'b0, in_data.step_ms})
               > {1'b0, cfg.lifetime_ms};
    diff     = cfg.lifetime_ms - in_data.set_age_ms;
    na       = {diff, 8'b0} - {8'b0, diff};
  end

  // Stages 2..NSTG: restoring division by lifetime, DIV_STEP bits each
  always_comb begin
    logic [RW-1:0] ra;
    logic [RW-1:0] rg;
    logic [RW-1:0] dv;
    logic [QT-1:0] qa;
    logic [QT-1:0] qg;
    int            k;
    for (int j = 2; j <= NSTG; j++) begin
      ra = rem_a_r[j-1];
      rg = rem_g_r[j-1];
      qa = q_a_r[j-1];
      qg = q_g_r[j-1];
      for (int s = 0; s < DIV_STEP; s++) begin
        k  = QT - 1 - (j - 2) * DIV_STEP - s;
        dv = RW'(cfg.lifetime_ms) << k;
        if (ra >= dv) begin
          ra = ra - dv;
          qa = qa | (QT'(1) << k);
        end
        if (rg >= dv) begin
          rg = rg - dv;
          qg = qg | (QT'(1) << k);
        end
      end
      rem_a_nxt[j] = ra;
      rem_g_nxt[j] = rg;
      q_a_nxt[j]   = qa;
      q_g_nxt[j]   = qg;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      rem_a_r[1] <= lt1_nxt ? RW'(na) : '0;
      rem_g_r[1] <= lt1_nxt ? RW'({in_data.set_age_ms, {FADE_TABLE_BITS{1'b0}}}) : '0;
      q_a_r[1]   <= '0;
      q_g_r[1]   <= '0;
      lt_r[1]    <= lt1_nxt;
      exp_r[1]   <= exp1_nxt;
    end
    for (int j = 2; j <= NSTG; j++) begin
      if (stg_en[j]) begin
        q_a_r[j] <= q_a_nxt[j];
        q_g_r[j] <= q_g_nxt[j];
        lt_r[j]  <= lt_r[j-1];
        exp_r[j] <= exp_r[j-1];
      end
    end
    for (int j = 2; j < NSTG; j++) begin
      if (stg_en[j]) begin
        rem_a_r[j] <= rem_a_nxt[j];
        rem_g_r[j] <= rem_g_nxt[j];
      end
    end
  end

  // Colors are zero once the set has reached its lifetime
  assign alpha   = lt_r[NSTG] ? q_a_r[NSTG][7:0] : 8'd0;
  assign green   = lt_r[NSTG] ? FADE_TAB[q_g_r[NSTG][FADE_TABLE_BITS-1:0]] : 8'd0;
  assign expired = exp_r[NSTG];

endmodule

`default_nettype wire

// ===== rtl/core/particle_motion_update.sv =====
`default_nettype none

// Port     Handshake              Payload                 Carries
// in_      in_valid / in_ready    in_data (pmu_in_t)      particle request
// out_     out_valid / out_ready  out_data (pmu_out_t)    updated particle
// cfg_     cfg_wr_en              cfg_index, cfg_wdata    register write
//
// One request per cycle unless an output stall backs up to the input. The depth
// is set by the lifetime division: four stages of DIV_STEP quotient bits each,
// after one setup stage and before the output register.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults. A stage advances when it is empty or the next one
// advances, so bubbles fill up under an output stall and nothing is lost.

module particle_motion_update import pmu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pmu_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pmu_out_t               out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  // Configuration registers
  pmu_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity_q24  <= GRAVITY_RST;
      cfg_r.drag_q16     <= DRAG_RST;
      cfg_r.ground_level <= GROUND_RST;
      cfg_r.screen_width <= WIDTH_RST;
      cfg_r.lifetime_ms  <= LIFETIME_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRAVITY:  cfg_r.gravity_q24  <= cfg_wdata;
        REG_DRAG:     cfg_r.drag_q16     <= cfg_wdata[15:0];
        REG_GROUND:   cfg_r.ground_level <= cfg_wdata[11:0];
        REG_WIDTH:    cfg_r.screen_width <= cfg_wdata[11:0];
        REG_LIFETIME: cfg_r.lifetime_ms  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Stage valids and the advance chain
  logic [NSTG:1]   vld_r, vld_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [NSTG+1:1] stg_en;

  always_comb begin
    stg_en[NSTG+1] = !out_valid_r || out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  always_comb begin
    vld_nxt[1] = stg_en[1] ? in_valid : vld_r[1];
    for (int k = 2; k <= NSTG; k++) begin
      vld_nxt[k] = stg_en[k] ? vld_r[k-1] : vld_r[k];
    end
    out_valid_nxt = stg_en[NSTG+1] ? vld_r[NSTG] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapaths
  logic signed [23:0] mo_pos_x, mo_pos_y, mo_vel_x, mo_vel_y;
  logic        [7:0]  fd_alpha, fd_green;
  logic               fd_expired;

  pmu_motion u_motion (
    .clk       (clk),
    .stg_en    (stg_en[NSTG:1]),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .new_pos_x (mo_pos_x),
    .new_pos_y (mo_pos_y),
    .new_vel_x (mo_vel_x),
    .new_vel_y (mo_vel_y)
  );

  pmu_fade u_fade (
    .clk     (clk),
    .stg_en  (stg_en[NSTG:1]),
    .cfg     (cfg_r),
    .in_data (in_data),
    .alpha   (fd_alpha),
    .green   (fd_green),
    .expired (fd_expired)
  );

  // Output register
  pmu_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (stg_en[NSTG+1]) begin
      out_data_r.new_pos_x <= mo_pos_x;
      out_data_r.new_pos_y <= mo_pos_y;
      out_data_r.new_vel_x <= mo_vel_x;
      out_data_r.new_vel_y <= mo_vel_y;
      out_data_r.alpha     <= fd_alpha;
      out_data_r.green     <= fd_green;
      out_data_r.expired   <= fd_expired;
    end
  end

  assign in_ready  = stg_en[1];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/pmu_checker.sv =====
`default_nettype none

module pmu_checker import pmu_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire pmu_out_t          out_data
);

  localparam int CW = $clog2(NSTG + 2);

  // Requests inside the block: taken but not yet delivered
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Wrapped x is never negative
  a_x_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.new_pos_x[23])
    else $error("x position outside the screen");

  // No result without a request behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result without a request");

  // Occupancy stays within the pipeline depth
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NSTG + 1))
    else $error("more requests inside than stages");

endmodule

bind particle_motion_update pmu_checker u_pmu_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
  import pmu_pkg::*;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  pmu_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pmu_out_t          out_data;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // Testbench copy of the registers and the green fade curve
  pmu_cfg_t   regs;
  logic [7:0] green_lut [FADE_SIZE];

  pmu_in_t  particle_q [$];   // requests waiting for the driver
  pmu_out_t predicted_q [$];  // predicted updates, oldest first

  int  n_queued   = 0;
  int  n_acc      = 0;
  int  n_rx       = 0;
  int  n_err      = 0;
  int  n_settings = 1;
  int  tx_wait    = 0;
  int  rx_wait    = 0;
  bit  tx_idle    = 1'b0;
  bit  rx_idle    = 1'b0;

  pmu_out_t   want;
  logic [6:0] bad;

  particle_motion_update dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .cfg_wr_en,
    .cfg_index,
    .cfg_wdata
  );

  always #5 clk = ~clk;

  // Floor square root, one result bit per pass
  function automatic bit [63:0] root64(input bit [63:0] v);
    bit [63:0] res;
    bit [63:0] trial;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= v) res = trial;
    end
    return res;
  endfunction

  // Round to nearest on a right shift, ties upward
  function automatic longint round_shr(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Expected update of one particle under the current register values
  function automatic pmu_out_t advance_particle(input pmu_in_t p);
    longint   x, y, vx, vy, dt, age, life, wlim, glim, g, keep;
    pmu_out_t r;
    x    = $signed(p.pos_x);
    y    = $signed(p.pos_y);
    vx   = $signed(p.vel_x);
    vy   = $signed(p.vel_y);
    dt   = longint'(p.step_ms);
    age  = longint'(p.set_age_ms);
    life = longint'(regs.lifetime_ms);
    wlim = longint'(regs.screen_width) << 8;
    glim = longint'(regs.ground_level) << 8;
    g    = longint'(regs.gravity_q24);
    keep = 65536 - longint'(regs.drag_q16);
    r    = '0;

    // horizontal: drag, move, wrap
    vx = clamp24(round_shr(vx * keep, 16));
    x  = x + round_shr(vx * dt, 8);
    if (x < 0) x = wlim;
    if (x > wlim) x = 0;

    // vertical: ground clamp and bounce, then drag and gravity
    if (y > glim) begin
      y = glim;
      if (vy > 0) vy = round_shr(-vy, 1);
    end
    vy = round_shr(vy * keep, 16);
    y  = clamp24(y + round_shr(vy * dt * 512 + g * dt * dt, 17));
    vy = clamp24(vy + round_shr(g * dt, 8));

    // fade colors, zero once the set has reached its lifetime
    if (age < life) begin
      r.alpha = 8'((255 * (life - age)) / life);
      r.green = green_lut[((age << FADE_TABLE_BITS) / life) & longint'(FADE_SIZE - 1)];
    end
    r.expired   = (age + dt > life);
    r.new_pos_x = 24'(x);
    r.new_pos_y = 24'(y);
    r.new_vel_x = 24'(vx);
    r.new_vel_y = 24'(vy);
    return r;
  endfunction

  function automatic logic [23:0] wild24();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  // Random particle, mostly near the screen, the ground and the lifetime edge
  function automatic pmu_in_t rand_particle();
    pmu_in_t p;
    longint  wl, gl, life;
    wl   = longint'(regs.screen_width) << 8;
    gl   = longint'(regs.ground_level) << 8;
    life = longint'(regs.lifetime_ms);

    case ($urandom_range(0, 3))
      0: p.pos_x = wild24();
      1: p.pos_x = 24'(longint'($urandom_range(0, 4096)) - 2048);
      2: p.pos_x = 24'(wl + longint'($urandom_range(0, 4096)) - 2048);
      default: p.pos_x = 24'(longint'($urandom_range(0, 32'(wl))));
    endcase
    case ($urandom_range(0, 3))
      0: p.pos_y = wild24();
      1: p.pos_y = 24'(gl + longint'($urandom_range(0, 8192)) - 4096);
      2: p.pos_y = 24'(longint'($urandom_range(0, 32'(gl))));
      default: p.pos_y = 24'(gl + longint'($urandom_range(0, 65535)));
    endcase
    p.vel_x = ($urandom_range(0, 3) == 0) ? wild24()
            : 24'(longint'($urandom_range(0, 1 << 19)) - (1 << 18));
    p.vel_y = ($urandom_range(0, 3) == 0) ? wild24()
            : 24'(longint'($urandom_range(0, 1 << 19)) - (1 << 18));
    case ($urandom_range(0, 3))
      0: p.step_ms = 8'($urandom_range(0, 255));
      1: p.step_ms = 8'($urandom_range(0, 1) * 255);
      default: p.step_ms = 8'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 3))
      0: p.set_age_ms = 16'($urandom_range(0, 65535));
      1: p.set_age_ms = 16'(life + longint'($urandom_range(0, 64)) - 32);
      2: p.set_age_ms = 16'(life - longint'(p.step_ms) + longint'($urandom_range(0, 2)) - 1);
      default: p.set_age_ms = 16'($urandom_range(0, 32'(life)));
    endcase
    return p;
  endfunction

  task automatic queue_particle(input longint x, y, vx, vy, input int dt, age);
    pmu_in_t p;
    p.pos_x      = 24'(x);
    p.pos_y      = 24'(y);
    p.vel_x      = 24'(vx);
    p.vel_y      = 24'(vy);
    p.step_ms    = 8'(dt);
    p.set_age_ms = 16'(age);
    particle_q.insert(particle_q.size(), p);
    n_queued++;
  endtask

  task automatic set_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_GRAVITY:  regs.gravity_q24  = val[23:0];
      REG_DRAG:     regs.drag_q16     = val[15:0];
      REG_GROUND:   regs.ground_level = val[11:0];
      REG_WIDTH:    regs.screen_width = val[11:0];
      REG_LIFETIME: regs.lifetime_ms  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [23:0] grav, input logic [15:0] drag,
                               input logic [11:0] ground, input logic [11:0] width,
                               input logic [15:0] life);
    set_reg(REG_GRAVITY, 24'(grav));
    set_reg(REG_DRAG, 24'(drag));
    set_reg(REG_GROUND, 24'(ground));
    set_reg(REG_WIDTH, 24'(width));
    set_reg(REG_LIFETIME, 24'(life));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // Block until every request is in and every update is out, then let it settle
  task automatic wait_idle();
    @(posedge clk);
    while (n_acc != n_queued || predicted_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Random requests in chunks, each chunk with its own idling mix
  task automatic run_batch(input int count);
    int chunk;
    while (count > 0) begin
      chunk = $urandom_range(20, 40);
      if (chunk > count) chunk = count;
      tx_idle = ($urandom_range(0, 2) != 0);
      rx_idle = ($urandom_range(0, 2) != 0);
      repeat (chunk) begin
        particle_q.insert(particle_q.size(), rand_particle());
        n_queued++;
      end
      count -= chunk;
      @(posedge clk);
      while (particle_q.size() > 2) @(posedge clk);
      if ($urandom_range(0, 3) == 0) wait_idle();
    end
  endtask

  // Driver: present queued requests, predict each one as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_q.insert(predicted_q.size(), advance_particle(in_data));
        n_acc++;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          in_valid <= 1'b0;
          tx_wait--;
        end else if (particle_q.size() != 0) begin
          in_data  <= particle_q.pop_front();
          in_valid <= 1'b1;
          tx_wait = tx_idle ? $urandom_range(0, 16) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each update against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected update %h", out_data);
        end else begin
          want = predicted_q.pop_front();
          bad = {want.new_pos_x !== out_data.new_pos_x,
                 want.new_pos_y !== out_data.new_pos_y,
                 want.new_vel_x !== out_data.new_vel_x,
                 want.new_vel_y !== out_data.new_vel_y,
                 want.alpha     !== out_data.alpha,
                 want.green     !== out_data.green,
                 want.expired   !== out_data.expired};
          if (bad != 0) begin
            n_err++;
            if (n_err <= 10) begin
              $display("update %0d bad fields %b (x y vx vy alpha green expired)", n_rx, bad);
              $display("  exp %h %h %h %h %h %h %b", want.new_pos_x, want.new_pos_y,
                       want.new_vel_x, want.new_vel_y, want.alpha, want.green, want.expired);
              $display("  got %h %h %h %h %h %h %b", out_data.new_pos_x, out_data.new_pos_y,
                       out_data.new_vel_x, out_data.new_vel_y, out_data.alpha, out_data.green,
                       out_data.expired);
            end
          end
        end
        n_rx++;
        // long output stall now and then so the pipeline backs up
        if (n_rx % 400 == 200) rx_wait = 150;
        else rx_wait = rx_idle ? $urandom_range(0, 16) : 0;
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    bit [63:0]   r, s, t, pw;
    logic [23:0] gsel;
    logic [15:0] dsel, lsel;

    // green fade curve: 255 * (1 - ratio^1.75)
    for (int i = 0; i < FADE_SIZE; i++) begin
      r  = 64'(i) << (30 - FADE_TABLE_BITS);
      s  = root64(r << 30);
      t  = root64(s << 30);
      pw = (((r * s) >> 30) * t) >> 30;
      green_lut[i] = 8'((64'd255 * ((64'd1 << 30) - pw)) >> 30);
    end
    regs = '{gravity_q24: GRAVITY_RST, drag_q16: DRAG_RST, ground_level: GROUND_RST,
             screen_width: WIDTH_RST, lifetime_ms: LIFETIME_RST};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at reset values (ground 720 px, width 1280 px, lifetime 500)
    queue_particle(0, 0, 0, 0, 0, 0);
    queue_particle(8388607, 8388607, 8388607, 8388607, 255, 65535);
    queue_particle(-8388608, -8388608, -8388608, -8388608, 0, 0);
    queue_particle(0, 1000, -65536, 0, 10, 100);          // wraps off the left edge
    queue_particle(327670, 1000, 65536, 0, 10, 100);      // wraps off the right edge
    queue_particle(327680, 1000, 0, 0, 5, 100);           // sits exactly on the width
    queue_particle(-100, 0, 100, 0, 1, 499);
    queue_particle(1000, 186880, 0, 196608, 16, 200);     // below ground, falling: bounce
    queue_particle(1000, 204800, 0, -131072, 16, 200);    // below ground, rising
    queue_particle(1000, 184320, 0, 65536, 16, 200);      // exactly on the ground
    queue_particle(1000, 184321, 0, 3, 1, 10);            // odd speed halved on bounce
    queue_particle(500, 500, 1000, -1000, 1, 499);        // age+step equals lifetime
    queue_particle(500, 500, 1000, -1000, 2, 499);        // one past lifetime
    queue_particle(500, 500, 1000, -1000, 3, 500);        // age at lifetime
    queue_particle(500, 500, 1000, -1000, 16, 250);
    queue_particle(500, 500, 1000, -1000, 16, 1);
    queue_particle(0, 8000, 0, 8388607, 255, 0);          // y saturates high
    queue_particle(0, -8388608, 0, -8388608, 255, 10);    // y saturates low
    queue_particle(100, 100, -1, -1, 1, 0);
    run_batch(160);

    // Register settings: all zero, all max, unit values, then random
    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      case (ph)
        0: load_settings(24'h0, 16'h0, 12'h0, 12'h0, 16'h0);
        1: load_settings(24'hFFFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 16'hFFFF);
        2: load_settings(24'hFFFFFF, 16'h0, 12'hFFF, 12'd1, 16'd1);
        default: begin
          gsel = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 60000));
          dsel = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 8000));
          lsel = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(1, 3000));
          load_settings(gsel, dsel, 12'($urandom_range(0, 4095)),
                        12'($urandom_range(1, 4095)), lsel);
        end
      endcase
      run_batch(180);
    end
    wait_idle();

    $display("covered %0d particle updates across %0d register settings", n_rx, n_settings);
    $display("(defaults, all-zero, all-max, unit width/lifetime, random); mismatches: %0d",
             n_err);
    if (n_err == 0 && predicted_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
